// File: hdl/nggp_pkg.sv
`default_nettype none
package nggp_pkg;

  localparam int unsigned NUM_SLOTS   = 12;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned ACC_W       = 30;
  localparam int unsigned TEXT_W      = 48;
  localparam int unsigned PROD_W      = 44;
  localparam int unsigned VAL_W       = PROD_W + 1;

  localparam logic [3:0] FLD_HEADER  = 4'd0;
  localparam logic [3:0] FLD_TIME    = 4'd1;
  localparam logic [3:0] FLD_LAT     = 4'd2;
  localparam logic [3:0] FLD_NS      = 4'd3;
  localparam logic [3:0] FLD_LON     = 4'd4;
  localparam logic [3:0] FLD_EW      = 4'd5;
  localparam logic [3:0] FLD_FIX     = 4'd6;
  localparam logic [3:0] FLD_SATS    = 4'd7;
  localparam logic [3:0] FLD_HDOP    = 4'd8;
  localparam logic [3:0] FLD_ALT     = 4'd9;
  localparam logic [3:0] FLD_GEOID   = 4'd11;
  localparam logic [3:0] FLD_AGE     = 4'd13;
  localparam logic [3:0] FLD_STATION = 4'd14;
  localparam logic [3:0] LAST_FIELD  = 4'd14;
  localparam logic [3:0] DONE_FIELD  = 4'd15;

  localparam logic [3:0] SLOT_TIME    = 4'd0;
  localparam logic [3:0] SLOT_LAT     = 4'd1;
  localparam logic [3:0] SLOT_NS      = 4'd2;
  localparam logic [3:0] SLOT_LON     = 4'd3;
  localparam logic [3:0] SLOT_EW      = 4'd4;
  localparam logic [3:0] SLOT_FIX     = 4'd5;
  localparam logic [3:0] SLOT_SATS    = 4'd6;
  localparam logic [3:0] SLOT_HDOP    = 4'd7;
  localparam logic [3:0] SLOT_ALT     = 4'd8;
  localparam logic [3:0] SLOT_GEOID   = 4'd9;
  localparam logic [3:0] SLOT_AGE     = 4'd10;
  localparam logic [3:0] SLOT_STATION = 4'd11;
  localparam logic [3:0] SLOT_NONE    = 4'd15;

  localparam logic [ACC_W-1:0] ACC_CAP = 30'd1000000000;
  localparam logic [3:0]       CNT_MAX = 4'd15;
  localparam logic [2:0]       FD_MAX  = 3'd5;
  localparam logic signed [31:0] AGE_EMPTY = -32'sd10;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_TEXT,
    KIND_NUM
  } field_kind_t;

  typedef struct packed {
    logic [3:0]         slot;
    field_kind_t        kind;
    logic [3:0]         limit;
    logic [2:0]         frac;
    logic               sign_ok;
    logic               empty_mark;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } field_spec_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eob;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_dot;
    logic       is_sign;
    logic       is_minus;
    logic       is_comma;
    logic       is_star;
    logic       is_nul;
  } tok_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic              emit;
    logic [3:0]        fld;
    logic [ACC_W-1:0]  acc;
    logic [2:0]        fd;
    logic              minus;
    logic [3:0]        cnt;
    logic [TEXT_W-1:0] text;
  } req_t;

  function automatic field_spec_t spec_of(input logic [3:0] fld);
    field_spec_t s;
    s = '{SLOT_NONE, KIND_SKIP, 4'd0, 3'd0, 1'b0, 1'b0, 32'sd0, 32'sd0};
    case (fld)
      FLD_TIME:    s = '{SLOT_TIME, KIND_TEXT, 4'd6, 3'd0, 1'b0, 1'b0, 32'sd0, 32'sd0};
      FLD_LAT:     s = '{SLOT_LAT, KIND_NUM, 4'd9, 3'd4, 1'b0, 1'b0, 32'sd0, 32'sd99999999};
      FLD_NS:      s = '{SLOT_NS, KIND_TEXT, 4'd1, 3'd0, 1'b0, 1'b0, 32'sd0, 32'sd0};
      FLD_LON:     s = '{SLOT_LON, KIND_NUM, 4'd10, 3'd4, 1'b0, 1'b0, 32'sd0, 32'sd999999999};
      FLD_EW:      s = '{SLOT_EW, KIND_TEXT, 4'd1, 3'd0, 1'b0, 1'b0, 32'sd0, 32'sd0};
      FLD_FIX:     s = '{SLOT_FIX, KIND_NUM, 4'd0, 3'd0, 1'b0, 1'b0, 32'sd0, 32'sd15};
      FLD_SATS:    s = '{SLOT_SATS, KIND_NUM, 4'd2, 3'd0, 1'b0, 1'b0, 32'sd0, 32'sd99};
      FLD_HDOP:    s = '{SLOT_HDOP, KIND_NUM, 4'd0, 3'd1, 1'b1, 1'b0, 32'sd0, 32'sd999};
      FLD_ALT:     s = '{SLOT_ALT, KIND_NUM, 4'd0, 3'd1, 1'b1, 1'b0, -32'sd99999, 32'sd999999};
      FLD_GEOID:   s = '{SLOT_GEOID, KIND_NUM, 4'd0, 3'd1, 1'b1, 1'b0, -32'sd99999, 32'sd99999};
      FLD_AGE:     s = '{SLOT_AGE, KIND_NUM, 4'd0, 3'd1, 1'b1, 1'b1, AGE_EMPTY, 32'sd99999};
      FLD_STATION: s = '{SLOT_STATION, KIND_TEXT, 4'd4, 3'd0, 1'b0, 1'b0, 32'sd0, 32'sd0};
      default:     s = '{SLOT_NONE, KIND_SKIP, 4'd0, 3'd0, 1'b0, 1'b0, 32'sd0, 32'sd0};
    endcase
    return s;
  endfunction

  function automatic logic [13:0] pow10(input logic [2:0] k);
    logic [13:0] p;
    case (k)
      3'd0:    p = 14'd1;
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      default: p = 14'd10000;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// File: hdl/nmea_gga_field_parser_top.sv
// GGA sentence parser: feed one character per word, one word per clock sustained while
// the output side does not hold the flow; the record word for the character flagged as end
// of buffer passes the front classify register, the queue, the parse stage and the record
// stage, and the output register lets the next sentence keep flowing while a record waits
// to be taken. The rate is set by the parse stage, which updates the field state for one
// character per clock while the record stage takes its requests. Fields a sentence never
// reaches keep their last values; reset clears the whole record to zero.
`default_nettype none
module nmea_gga_field_parser_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_char_code,
  input  wire logic          in_end_of_buffer,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [47:0]        out_utc_time_text,
  output logic [26:0]        out_latitude_e4,
  output logic [7:0]         out_north_south,
  output logic [29:0]        out_longitude_e4,
  output logic [7:0]         out_east_west,
  output logic [3:0]         out_fix_status,
  output logic [6:0]         out_satellite_count,
  output logic [9:0]         out_hdop_tenths,
  output logic signed [20:0] out_altitude_tenths,
  output logic signed [17:0] out_geoid_tenths,
  output logic signed [17:0] out_correction_age_tenths,
  output logic [31:0]        out_station_text
);

  logic           f_valid;
  logic           f_ready;
  nggp_pkg::tok_t f_tok;
  logic           q_valid;
  logic           q_ready;
  nggp_pkg::tok_t q_tok;
  logic           r_valid;
  logic           r_ready;
  nggp_pkg::req_t r_req;

  nggp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_end_of_buffer (in_end_of_buffer),
    .tok_valid        (f_valid),
    .tok_ready        (f_ready),
    .tok              (f_tok)
  );

  nggp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_tok),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_tok)
  );

  nggp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (q_valid),
    .tok_ready (q_ready),
    .tok       (q_tok),
    .req_valid (r_valid),
    .req_ready (r_ready),
    .req       (r_req)
  );

  nggp_record u_record (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .req_valid                 (r_valid),
    .req_ready                 (r_ready),
    .req                       (r_req),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_utc_time_text         (out_utc_time_text),
    .out_latitude_e4           (out_latitude_e4),
    .out_north_south           (out_north_south),
    .out_longitude_e4          (out_longitude_e4),
    .out_east_west             (out_east_west),
    .out_fix_status            (out_fix_status),
    .out_satellite_count       (out_satellite_count),
    .out_hdop_tenths           (out_hdop_tenths),
    .out_altitude_tenths       (out_altitude_tenths),
    .out_geoid_tenths          (out_geoid_tenths),
    .out_correction_age_tenths (out_correction_age_tenths),
    .out_station_text          (out_station_text)
  );

endmodule
`default_nettype wire

// File: hdl/nggp_front.sv
`default_nettype none
module nggp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_char_code,
  input  wire logic          in_end_of_buffer,
  output logic               tok_valid,
  input  wire logic          tok_ready,
  output nggp_pkg::tok_t     tok
);

  logic           valid_r;
  logic           valid_nxt;
  nggp_pkg::tok_t tok_r;
  nggp_pkg::tok_t tok_nxt;
  logic           take;

  assign in_ready  = !valid_r || tok_ready;
  assign take      = in_valid && in_ready;
  assign valid_nxt = take || (valid_r && !tok_ready);
  assign tok_valid = valid_r;
  assign tok       = tok_r;

  always_comb begin
    tok_nxt.ch       = in_char_code;
    tok_nxt.eob      = in_end_of_buffer;
    tok_nxt.is_digit = in_char_code inside {[nggp_pkg::CH_ZERO:nggp_pkg::CH_NINE]};
    tok_nxt.digit    = in_char_code[3:0];
    tok_nxt.is_dot   = in_char_code == nggp_pkg::CH_DOT;
    tok_nxt.is_sign  = in_char_code inside {nggp_pkg::CH_PLUS, nggp_pkg::CH_MINUS};
    tok_nxt.is_minus = in_char_code == nggp_pkg::CH_MINUS;
    tok_nxt.is_comma = in_char_code == nggp_pkg::CH_COMMA;
    tok_nxt.is_star  = in_char_code == nggp_pkg::CH_STAR;
    tok_nxt.is_nul   = in_char_code == nggp_pkg::CH_NUL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok_r <= tok_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/nggp_fifo.sv
`default_nettype none
module nggp_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  input  wire nggp_pkg::tok_t  wr_data,
  output logic                 rd_valid,
  input  wire logic            rd_ready,
  output nggp_pkg::tok_t       rd_data
);

  localparam logic [nggp_pkg::QUEUE_AW:0] FULL_CNT =
    (nggp_pkg::QUEUE_AW + 1)'(nggp_pkg::QUEUE_DEPTH);
  localparam logic [nggp_pkg::QUEUE_AW-1:0] LAST_PTR =
    nggp_pkg::QUEUE_AW'(nggp_pkg::QUEUE_DEPTH - 1);

  nggp_pkg::tok_t                mem_r [nggp_pkg::QUEUE_DEPTH];
  logic [nggp_pkg::QUEUE_AW-1:0] wptr_r;
  logic [nggp_pkg::QUEUE_AW-1:0] wptr_nxt;
  logic [nggp_pkg::QUEUE_AW-1:0] rptr_r;
  logic [nggp_pkg::QUEUE_AW-1:0] rptr_nxt;
  logic [nggp_pkg::QUEUE_AW:0]   cnt_r;
  logic [nggp_pkg::QUEUE_AW:0]   cnt_nxt;
  logic                          push;
  logic                          pop;

  assign wr_ready = cnt_r != FULL_CNT;
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

// File: hdl/nggp_parse.sv
`default_nettype none
module nggp_parse (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            tok_valid,
  output logic                 tok_ready,
  input  wire nggp_pkg::tok_t  tok,
  output logic                 req_valid,
  input  wire logic            req_ready,
  output nggp_pkg::req_t       req
);

  localparam int unsigned BYTES = nggp_pkg::TEXT_W / 8;

  logic [3:0]                  fld_r,   fld_nxt;
  logic                        ended_r, ended_nxt;
  logic [nggp_pkg::ACC_W-1:0]  acc_r,   acc_nxt;
  logic                        minus_r, minus_nxt;
  logic [2:0]                  fd_r,    fd_nxt;
  logic                        stop_r,  stop_nxt;
  logic [3:0]                  cnt_r,   cnt_nxt;
  logic [nggp_pkg::TEXT_W-1:0] text_r,  text_nxt;

  logic [nggp_pkg::ACC_W-1:0]  f_acc;
  logic                        f_minus;
  logic [2:0]                  f_fd;
  logic                        f_stop;
  logic [3:0]                  f_cnt;
  logic [nggp_pkg::TEXT_W-1:0] f_text;

  nggp_pkg::field_spec_t       sp;
  logic                        active;
  logic                        comma_sep;
  logic                        star_sep;
  logic                        sep;
  logic                        fire;
  logic [nggp_pkg::ACC_W+3:0]  acc_ext;
  logic [nggp_pkg::ACC_W-1:0]  acc_sat;

  assign sp        = nggp_pkg::spec_of(fld_r);
  assign active    = !ended_r && (fld_r != nggp_pkg::DONE_FIELD);
  assign comma_sep = tok.is_comma && (fld_r != nggp_pkg::LAST_FIELD);
  assign star_sep  = tok.is_star && (fld_r == nggp_pkg::LAST_FIELD);
  assign sep       = tok.is_nul || comma_sep || star_sep;

  assign acc_ext = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {30'b0, tok.digit};
  assign acc_sat = (acc_ext > {4'b0, nggp_pkg::ACC_CAP}) ? nggp_pkg::ACC_CAP
                                                          : acc_ext[nggp_pkg::ACC_W-1:0];

  always_comb begin
    f_acc   = acc_r;
    f_minus = minus_r;
    f_fd    = fd_r;
    f_stop  = stop_r;
    f_cnt   = cnt_r;
    f_text  = text_r;
    if (active && !sep) begin
      case (sp.kind)
        nggp_pkg::KIND_TEXT: begin
          if (cnt_r < sp.limit) begin
            for (int i = 0; i < BYTES; i++) begin
              if (4'(i) == sp.limit - 4'd1 - cnt_r) begin
                f_text[8*i +: 8] = tok.ch;
              end
            end
            f_cnt = cnt_r + 4'd1;
          end
        end
        nggp_pkg::KIND_NUM: begin
          f_cnt = (cnt_r == nggp_pkg::CNT_MAX) ? cnt_r : cnt_r + 4'd1;
          if (!stop_r && !(sp.limit != 4'd0 && cnt_r >= sp.limit)) begin
            if (tok.is_digit) begin
              if (fd_r == 3'd0) begin
                f_acc = acc_sat;
              end else if (fd_r - 3'd1 < sp.frac) begin
                f_fd  = fd_r + 3'd1;
                f_acc = acc_sat;
              end
            end else if (tok.is_dot && fd_r == 3'd0 && sp.frac != 3'd0) begin
              f_fd = 3'd1;
            end else if (tok.is_sign && cnt_r == 4'd0 && sp.sign_ok) begin
              f_minus = tok.is_minus;
            end else begin
              f_stop = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    req.full  = active && (sep || tok.eob);
    req.empty = active && comma_sep && tok.eob;
    req.emit  = tok.eob;
    req.fld   = fld_r;
    req.acc   = f_acc;
    req.fd    = f_fd;
    req.minus = f_minus;
    req.cnt   = f_cnt;
    req.text  = f_text;
  end

  assign tok_ready = req_ready;
  assign req_valid = tok_valid && (req.full || req.empty || req.emit);
  assign fire      = tok_valid && tok_ready;

  always_comb begin
    fld_nxt   = fld_r;
    ended_nxt = ended_r;
    acc_nxt   = acc_r;
    minus_nxt = minus_r;
    fd_nxt    = fd_r;
    stop_nxt  = stop_r;
    cnt_nxt   = cnt_r;
    text_nxt  = text_r;
    if (fire) begin
      if (tok.eob || (active && (comma_sep || star_sep))) begin
        acc_nxt   = '0;
        minus_nxt = 1'b0;
        fd_nxt    = '0;
        stop_nxt  = 1'b0;
        cnt_nxt   = '0;
        text_nxt  = '0;
      end
      if (tok.eob) begin
        fld_nxt   = nggp_pkg::FLD_HEADER;
        ended_nxt = 1'b0;
      end else if (active) begin
        if (tok.is_nul) begin
          ended_nxt = 1'b1;
        end else if (comma_sep) begin
          fld_nxt = fld_r + 4'd1;
        end else if (star_sep) begin
          fld_nxt = nggp_pkg::DONE_FIELD;
        end else begin
          acc_nxt   = f_acc;
          minus_nxt = f_minus;
          fd_nxt    = f_fd;
          stop_nxt  = f_stop;
          cnt_nxt   = f_cnt;
          text_nxt  = f_text;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fld_r   <= nggp_pkg::FLD_HEADER;
      ended_r <= 1'b0;
      acc_r   <= '0;
      minus_r <= 1'b0;
      fd_r    <= '0;
      stop_r  <= 1'b0;
      cnt_r   <= '0;
      text_r  <= '0;
    end else begin
      fld_r   <= fld_nxt;
      ended_r <= ended_nxt;
      acc_r   <= acc_nxt;
      minus_r <= minus_nxt;
      fd_r    <= fd_nxt;
      stop_r  <= stop_nxt;
      cnt_r   <= cnt_nxt;
      text_r  <= text_nxt;
    end
  end

  a_ended_field: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |-> fld_r != nggp_pkg::DONE_FIELD)
    else $error("sentence ended after station field closed");

  a_fd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fd_r <= nggp_pkg::FD_MAX)
    else $error("fraction digit count out of range");

endmodule
`default_nettype wire

// File: hdl/nggp_record.sv
`default_nettype none
module nggp_record (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire nggp_pkg::req_t  req,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [47:0]          out_utc_time_text,
  output logic [26:0]          out_latitude_e4,
  output logic [7:0]           out_north_south,
  output logic [29:0]          out_longitude_e4,
  output logic [7:0]           out_east_west,
  output logic [3:0]           out_fix_status,
  output logic [6:0]           out_satellite_count,
  output logic [9:0]           out_hdop_tenths,
  output logic signed [20:0]   out_altitude_tenths,
  output logic signed [17:0]   out_geoid_tenths,
  output logic signed [17:0]   out_correction_age_tenths,
  output logic [31:0]          out_station_text
);

  localparam int unsigned VW = nggp_pkg::VAL_W;
  localparam int unsigned TW = nggp_pkg::TEXT_W;

  logic                         b_valid_r, b_valid_nxt;
  nggp_pkg::req_t               b_req_r;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_ok;
  logic                         b_fire;
  logic                         load_out;

  logic [TW-1:0]                rec_r   [nggp_pkg::NUM_SLOTS];
  logic [TW-1:0]                rec_nxt [nggp_pkg::NUM_SLOTS];

  nggp_pkg::field_spec_t        sp;
  nggp_pkg::field_spec_t        esp;
  logic [3:0]                   efld;
  logic [2:0]                   have;
  logic [2:0]                   scale;
  logic [nggp_pkg::PROD_W-1:0]  prod;
  logic signed [VW-1:0]         mag;
  logic signed [VW-1:0]         val;
  logic signed [VW-1:0]         lo_ext;
  logic signed [VW-1:0]         hi_ext;
  logic signed [VW-1:0]         clamped;
  logic [TW-1:0]                full_val;
  logic [TW-1:0]                empty_val;

  logic [47:0]                  time_r;
  logic [26:0]                  lat_r;
  logic [7:0]                   ns_r;
  logic [29:0]                  lon_r;
  logic [7:0]                   ew_r;
  logic [3:0]                   fix_r;
  logic [6:0]                   sats_r;
  logic [9:0]                   hdop_r;
  logic signed [20:0]           alt_r;
  logic signed [17:0]           geoid_r;
  logic signed [17:0]           age_r;
  logic [31:0]                  station_r;

  assign out_ok        = !out_valid_r || out_ready;
  assign b_fire        = b_valid_r && (!b_req_r.emit || out_ok);
  assign req_ready     = !b_valid_r || b_fire;
  assign load_out      = b_fire && b_req_r.emit;
  assign b_valid_nxt   = (req_valid && req_ready) || (b_valid_r && !b_fire);
  assign out_valid_nxt = load_out || (out_valid_r && !out_ready);

  assign sp   = nggp_pkg::spec_of(b_req_r.fld);
  assign efld = b_req_r.fld + 4'd1;
  assign esp  = nggp_pkg::spec_of(efld);

  always_comb begin
    have    = (b_req_r.fd == 3'd0) ? 3'd0 : b_req_r.fd - 3'd1;
    scale   = (sp.frac > have) ? sp.frac - have : 3'd0;
    prod    = nggp_pkg::PROD_W'(b_req_r.acc) * nggp_pkg::PROD_W'(nggp_pkg::pow10(scale));
    mag     = signed'({1'b0, prod});
    val     = b_req_r.minus ? -mag : mag;
    lo_ext  = VW'(sp.lo);
    hi_ext  = VW'(sp.hi);
    clamped = val;
    if (val < lo_ext) begin
      clamped = lo_ext;
    end
    if (val > hi_ext) begin
      clamped = hi_ext;
    end
    case (sp.kind)
      nggp_pkg::KIND_TEXT: full_val = b_req_r.text;
      nggp_pkg::KIND_NUM: begin
        if (sp.empty_mark && b_req_r.cnt == 4'd0) begin
          full_val = TW'(nggp_pkg::AGE_EMPTY);
        end else begin
          full_val = TW'(clamped);
        end
      end
      default: full_val = '0;
    endcase
    empty_val = esp.empty_mark ? TW'(nggp_pkg::AGE_EMPTY) : '0;
  end

  always_comb begin
    rec_nxt = rec_r;
    if (b_fire) begin
      if (b_req_r.full && sp.kind != nggp_pkg::KIND_SKIP) begin
        rec_nxt[sp.slot] = full_val;
      end
      if (b_req_r.empty && esp.kind != nggp_pkg::KIND_SKIP) begin
        rec_nxt[esp.slot] = empty_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < nggp_pkg::NUM_SLOTS; i++) begin
        rec_r[i] <= '0;
      end
    end else begin
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
      rec_r       <= rec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      b_req_r <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      time_r    <= rec_nxt[nggp_pkg::SLOT_TIME][47:0];
      lat_r     <= rec_nxt[nggp_pkg::SLOT_LAT][26:0];
      ns_r      <= rec_nxt[nggp_pkg::SLOT_NS][7:0];
      lon_r     <= rec_nxt[nggp_pkg::SLOT_LON][29:0];
      ew_r      <= rec_nxt[nggp_pkg::SLOT_EW][7:0];
      fix_r     <= rec_nxt[nggp_pkg::SLOT_FIX][3:0];
      sats_r    <= rec_nxt[nggp_pkg::SLOT_SATS][6:0];
      hdop_r    <= rec_nxt[nggp_pkg::SLOT_HDOP][9:0];
      alt_r     <= signed'(rec_nxt[nggp_pkg::SLOT_ALT][20:0]);
      geoid_r   <= signed'(rec_nxt[nggp_pkg::SLOT_GEOID][17:0]);
      age_r     <= signed'(rec_nxt[nggp_pkg::SLOT_AGE][17:0]);
      station_r <= rec_nxt[nggp_pkg::SLOT_STATION][31:0];
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_utc_time_text         = time_r;
  assign out_latitude_e4           = lat_r;
  assign out_north_south           = ns_r;
  assign out_longitude_e4          = lon_r;
  assign out_east_west             = ew_r;
  assign out_fix_status            = fix_r;
  assign out_satellite_count       = sats_r;
  assign out_hdop_tenths           = hdop_r;
  assign out_altitude_tenths       = alt_r;
  assign out_geoid_tenths          = geoid_r;
  assign out_correction_age_tenths = age_r;
  assign out_station_text          = station_r;

  a_hold_req: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && !b_fire |=> b_valid_r && $stable(b_req_r))
    else $error("stalled finish request lost or changed");

  a_two_slots: assert property (@(posedge clk) disable iff (!rst_n)
    b_fire && b_req_r.full && b_req_r.empty |-> sp.slot != esp.slot)
    else $error("two record writes to one slot");

endmodule
`default_nettype wire
